// ----- sv/tfm_pkg.sv -----
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared types and constants for the topic filter matcher.
// ----------------------------------------------------------------------------
package tfm_pkg;

   // Characters with special meaning in filters and topics
   localparam logic [7:0] CHAR_SLASH = 8'h2F;  // level separator
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // single-level wildcard
   localparam logic [7:0] CHAR_HASH  = 8'h23;  // multi-level wildcard

   // Queue between front and back
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = 2;
   localparam int FQ_CNT_W = 3;

   // Result queue
   localparam int RQ_DEPTH = 2;
   localparam int RQ_PTR_W = 1;
   localparam int RQ_CNT_W = 2;

   // Classified request as it travels from front to back
   typedef struct packed {
      logic       is_topic;
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
      logic       is_slash;
      logic       is_plus;
      logic       is_hash;
   } item_type;

   // One result
   typedef struct packed {
      logic matched;
      logic filter_valid;
   } result_type;

   // Syntax flags of the filter level being loaded
   typedef struct packed {
      logic error;
      logic hash;
      logic plus;
      logic nonempty;
   } load_flags_type;

   // Topic comparison mode
   typedef enum logic [2:0] {
      MODE_START = 3'd0,
      MODE_CMP   = 3'd1,
      MODE_PLUS  = 3'd2,
      MODE_ALL   = 3'd3,
      MODE_FAIL  = 3'd4
   } match_mode_type;

   // Back-end sequencer
   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_STEP   = 2'd1,
      BK_FINISH = 2'd2
   } back_state_type;

endpackage

// ----- sv/tfm_front.sv -----
// ----------------------------------------------------------------------------
// tfm_front
// Accepts requests, classifies the byte and queues them for the back end.
// ----------------------------------------------------------------------------
module tfm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_func,
   input  logic [7:0]        req_data_byte,
   input  logic              req_byte_present,
   input  logic              req_last,
   output logic              head_valid,
   output tfm_pkg::item_type head_item,
   input  logic              head_pop
);

   tfm_pkg::item_type            fq_mem_ff [tfm_pkg::FQ_DEPTH];
   logic [tfm_pkg::FQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tfm_pkg::FQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tfm_pkg::FQ_CNT_W-1:0] count_ff, count_in;
   tfm_pkg::item_type            new_item;
   logic                         do_push;
   logic                         do_pop;

   // Classify the incoming byte
   always_comb begin
      new_item.is_topic     = req_func;
      new_item.data_byte    = req_data_byte;
      new_item.byte_present = req_byte_present;
      new_item.last         = req_last;
      new_item.is_slash     = (req_data_byte == tfm_pkg::CHAR_SLASH);
      new_item.is_plus      = (req_data_byte == tfm_pkg::CHAR_PLUS);
      new_item.is_hash      = (req_data_byte == tfm_pkg::CHAR_HASH);
   end

   assign req_full   = (count_ff == tfm_pkg::FQ_CNT_W'(tfm_pkg::FQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = fq_mem_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = head_pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         fq_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- sv/tfm_back.sv -----
// ----------------------------------------------------------------------------
// tfm_back
// Loads and checks the filter, compares topic bytes level by level and
// produces one result at the end of each topic.
// ----------------------------------------------------------------------------
module tfm_back #(
   parameter int MAX_FILTER_LEN = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  tfm_pkg::item_type   head_item,
   output logic                head_pop,
   input  logic                res_full,
   output logic                res_push,
   output tfm_pkg::result_type res_data
);

   localparam int AW = $clog2(MAX_FILTER_LEN);
   localparam int LW = $clog2(MAX_FILTER_LEN + 2);
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_FILTER_LEN);

   // Filter memory, read at the comparison point and the byte after it
   logic [7:0] filter_mem [MAX_FILTER_LEN];
   logic       mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0] rd0_ff, rd1_ff;
   logic [LW:0] rd1_addr;

   tfm_pkg::back_state_type state_ff, state_in;
   tfm_pkg::item_type       cur_ff, cur_in;
   tfm_pkg::load_flags_type flags_ff, flags_in;
   tfm_pkg::match_mode_type mode_ff, mode_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic          ok_ff, ok_in;
   logic          loading_ff, loading_in;
   logic          prev_slash_ff, prev_slash_in;
   logic          tail_ff, tail_in;
   logic          seen_ff, seen_in;

   // Level ends at e: filter also ends there, or continues with exactly "/#"
   function automatic logic end_ok(input logic [LW:0] e, input logic [LW-1:0] len,
                                   input logic tail);
      logic [LW+1:0] e2;
      e2 = {1'b0, e} + 2'd2;
      end_ok = (e >= {1'b0, len}) || (tail && (e2 == {2'b00, len}));
   endfunction

   // Sequencer, filter loading, topic step and topic end
   always_comb begin
      tfm_pkg::load_flags_type fl;
      logic [LW-1:0] lt;
      logic          ps;
      logic          v0;
      logic          v1;
      logic [LW:0]   p1;
      logic [LW:0]   p2;
      logic          f0_hash;
      logic          f0_plus;
      logic          f0_slash;
      logic          fin;

      state_in      = state_ff;
      cur_in        = cur_ff;
      flags_in      = flags_ff;
      mode_in       = mode_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      ok_in         = ok_ff;
      loading_in    = loading_ff;
      prev_slash_in = prev_slash_ff;
      tail_in       = tail_ff;
      seen_in       = seen_ff;
      head_pop      = 1'b0;
      res_push      = 1'b0;
      res_data      = '0;
      mem_we        = 1'b0;
      mem_waddr     = len_ff[AW-1:0];

      fl  = flags_ff;
      lt  = len_ff;
      ps  = prev_slash_ff;
      fin = 1'b0;

      v0       = ({1'b0, pos_ff} < {1'b0, len_ff});
      p1       = {1'b0, pos_ff} + 1'b1;
      p2       = {1'b0, pos_ff} + 2'd2;
      v1       = (p1 < {1'b0, len_ff});
      f0_hash  = v0 && (rd0_ff == tfm_pkg::CHAR_HASH);
      f0_plus  = v0 && (rd0_ff == tfm_pkg::CHAR_PLUS);
      f0_slash = v0 && (rd0_ff == tfm_pkg::CHAR_SLASH);

      case (state_ff)
         tfm_pkg::BK_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               if (!head_item.is_topic) begin
                  // Filter byte: abandon any topic, extend the filter
                  pos_in  = '0;
                  mode_in = tfm_pkg::MODE_START;
                  seen_in = 1'b0;
                  if (!loading_ff) begin
                     lt    = '0;
                     fl    = '0;
                     ok_in = 1'b0;
                     ps    = 1'b0;
                     tail_in = 1'b0;
                  end
                  loading_in = 1'b1;
                  if (head_item.byte_present) begin
                     if (lt < MAX_LEN) begin
                        mem_we    = 1'b1;
                        mem_waddr = lt[AW-1:0];
                        tail_in   = ps && head_item.is_hash;
                        ps        = head_item.is_slash;
                     end
                     if (lt <= MAX_LEN) begin
                        lt = lt + 1'b1;
                     end
                     // Level syntax check
                     if (head_item.is_slash) begin
                        fl = '{error: fl.error | fl.hash, hash: 1'b0, plus: 1'b0,
                               nonempty: 1'b0};
                     end else if (head_item.is_plus || head_item.is_hash) begin
                        fl.error    = fl.error | fl.nonempty;
                        fl.nonempty = 1'b1;
                        fl.plus     = fl.plus | head_item.is_plus;
                        fl.hash     = fl.hash | head_item.is_hash;
                     end else begin
                        fl.error    = fl.error | fl.plus | fl.hash;
                        fl.nonempty = 1'b1;
                     end
                  end
                  if (head_item.last) begin
                     ok_in      = !fl.error && (lt != '0) && (lt <= MAX_LEN);
                     loading_in = 1'b0;
                  end
                  len_in        = lt;
                  flags_in      = fl;
                  prev_slash_in = ps;
               end else begin
                  // Topic byte: hold it into the next cycle while the filter bytes are read
                  cur_in   = head_item;
                  state_in = tfm_pkg::BK_STEP;
               end
            end
         end

         tfm_pkg::BK_STEP: begin
            if (cur_ff.byte_present) begin
               seen_in = 1'b1;
               if (ok_ff) begin
                  case (mode_ff)
                     tfm_pkg::MODE_START: begin
                        if (f0_hash) begin
                           mode_in = tfm_pkg::MODE_ALL;
                        end else if (f0_plus) begin
                           if (cur_ff.is_slash) begin
                              if (v1 && (rd1_ff == tfm_pkg::CHAR_SLASH)) begin
                                 pos_in  = p2[LW-1:0];
                                 mode_in = tfm_pkg::MODE_START;
                              end else begin
                                 mode_in = tfm_pkg::MODE_FAIL;
                              end
                           end else begin
                              pos_in  = p1[LW-1:0];
                              mode_in = tfm_pkg::MODE_PLUS;
                           end
                        end else if (cur_ff.is_slash) begin
                           if (f0_slash) begin
                              pos_in  = p1[LW-1:0];
                              mode_in = tfm_pkg::MODE_START;
                           end else begin
                              mode_in = tfm_pkg::MODE_FAIL;
                           end
                        end else if (v0 && (rd0_ff == cur_ff.data_byte)) begin
                           pos_in  = p1[LW-1:0];
                           mode_in = tfm_pkg::MODE_CMP;
                        end else begin
                           mode_in = tfm_pkg::MODE_FAIL;
                        end
                     end
                     tfm_pkg::MODE_CMP: begin
                        if (cur_ff.is_slash) begin
                           if (f0_slash) begin
                              pos_in  = p1[LW-1:0];
                              mode_in = tfm_pkg::MODE_START;
                           end else begin
                              mode_in = tfm_pkg::MODE_FAIL;
                           end
                        end else if (v0 && (rd0_ff == cur_ff.data_byte)) begin
                           pos_in = p1[LW-1:0];
                        end else begin
                           mode_in = tfm_pkg::MODE_FAIL;
                        end
                     end
                     tfm_pkg::MODE_PLUS: begin
                        if (cur_ff.is_slash) begin
                           if (f0_slash) begin
                              pos_in  = p1[LW-1:0];
                              mode_in = tfm_pkg::MODE_START;
                           end else begin
                              mode_in = tfm_pkg::MODE_FAIL;
                           end
                        end
                     end
                     default: begin
                        mode_in = mode_ff;
                     end
                  endcase
               end
            end
            state_in = cur_ff.last ? tfm_pkg::BK_FINISH : tfm_pkg::BK_IDLE;
         end

         tfm_pkg::BK_FINISH: begin
            // End of topic: evaluate the remaining filter and emit
            case (mode_ff)
               tfm_pkg::MODE_ALL: fin = 1'b1;
               tfm_pkg::MODE_CMP, tfm_pkg::MODE_PLUS: begin
                  fin = end_ok({1'b0, pos_ff}, len_ff, tail_ff);
               end
               tfm_pkg::MODE_START: begin
                  if (f0_hash) begin
                     fin = 1'b1;
                  end else if (f0_plus) begin
                     fin = end_ok(p1, len_ff, tail_ff);
                  end else begin
                     fin = end_ok({1'b0, pos_ff}, len_ff, tail_ff);
                  end
               end
               default: fin = 1'b0;
            endcase
            if (!res_full) begin
               res_push              = 1'b1;
               res_data.matched      = ok_ff && seen_ff && fin;
               res_data.filter_valid = ok_ff;
               pos_in                = '0;
               mode_in               = tfm_pkg::MODE_START;
               seen_in               = 1'b0;
               state_in              = tfm_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = tfm_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tfm_pkg::BK_IDLE;
         flags_ff      <= '0;
         mode_ff       <= tfm_pkg::MODE_START;
         len_ff        <= '0;
         pos_ff        <= '0;
         ok_ff         <= 1'b0;
         loading_ff    <= 1'b0;
         prev_slash_ff <= 1'b0;
         tail_ff       <= 1'b0;
         seen_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flags_ff      <= flags_in;
         mode_ff       <= mode_in;
         len_ff        <= len_in;
         pos_ff        <= pos_in;
         ok_ff         <= ok_in;
         loading_ff    <= loading_in;
         prev_slash_ff <= prev_slash_in;
         tail_ff       <= tail_in;
         seen_ff       <= seen_in;
      end
   end

   // Current topic request
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Filter memory: one write port, two registered reads at the next position and the one after it
   assign rd1_addr = {1'b0, pos_in} + 1'b1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         filter_mem[mem_waddr] <= head_item.data_byte;
      end
      rd0_ff <= filter_mem[pos_in[AW-1:0]];
      rd1_ff <= filter_mem[rd1_addr[AW-1:0]];
   end

endmodule

// ----- sv/tfm_result_queue.sv -----
// ----------------------------------------------------------------------------
// tfm_result_queue
// Small queue holding results until the receiver pops them.
// ----------------------------------------------------------------------------
module tfm_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_push,
   input  tfm_pkg::result_type res_data,
   output logic                res_full,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_matched,
   output logic                rsp_filter_valid
);

   tfm_pkg::result_type          rq_mem_ff [tfm_pkg::RQ_DEPTH];
   logic [tfm_pkg::RQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tfm_pkg::RQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tfm_pkg::RQ_CNT_W-1:0] count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign res_full         = (count_ff == tfm_pkg::RQ_CNT_W'(tfm_pkg::RQ_DEPTH));
   assign rsp_empty        = (count_ff == '0);
   assign rsp_matched      = rq_mem_ff[rd_ptr_ff].matched;
   assign rsp_filter_valid = rq_mem_ff[rd_ptr_ff].filter_valid;
   assign do_push          = res_push && !res_full;
   assign do_pop           = rsp_pop && !rsp_empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         rq_mem_ff[wr_ptr_ff] <= res_data;
      end
   end

endmodule

// ----- sv/topic_filter_matcher_top.sv -----
// ----------------------------------------------------------------------------
// topic_filter_matcher_top
// Topic filter matcher with single-level and multi-level wildcards.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: drive the fields and req_push;
//   a request is taken on a clock edge where req_push is high and req_full
//   is low. req_func = 0 loads one filter byte, req_func = 1 feeds one topic
//   byte; req_last closes the current string.
//   Each topic's last request yields one result (matched, filter_valid),
//   shown on rsp_* while rsp_empty is low and removed by rsp_pop.
// Sequencing:
//   A four-entry request queue feeds the back end, which takes a filter byte
//   in its idle state, a topic byte in idle and then a step state (filter
//   memory read, then compare), and the last byte of a topic in one more
//   state that evaluates the end. The back end pops the next request only
//   once it is back in its idle state.
// Reset:
//   Synchronous reset empties both queues and forgets the filter, so topics
//   report filter_valid = 0 until a filter is loaded. Filter memory contents
//   are not cleared.
// Stalls:
//   With the two-entry result queue full, the back end holds the finishing
//   topic; the request queue then fills and req_full rises.
// ----------------------------------------------------------------------------
module topic_filter_matcher_top #(
   parameter int MAX_FILTER_LEN = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_matched,
   output logic       rsp_filter_valid
);

   logic                head_valid;
   tfm_pkg::item_type   head_item;
   logic                head_pop;
   logic                res_full;
   logic                res_push;
   tfm_pkg::result_type res_data;

   // Request queue with byte classification
   tfm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop)
   );

   // Filter store, loader and matcher
   tfm_back #(
      .MAX_FILTER_LEN (MAX_FILTER_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   // Result queue
   tfm_result_queue u_result_queue (
      .clock            (clock),
      .reset            (reset),
      .res_push         (res_push),
      .res_data         (res_data),
      .res_full         (res_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_matched      (rsp_matched),
      .rsp_filter_valid (rsp_filter_valid)
   );

   // Back end never pushes a result into a full result queue
   assert property (@(posedge clock) disable iff (reset) !(res_push && res_full))
      else $error("result pushed into full result queue");

   // Back end only pops the request queue when it holds a request
   assert property (@(posedge clock) disable iff (reset) head_pop |-> head_valid)
      else $error("request queue popped while empty");

   // A pushed match always comes with a valid filter
   assert property (@(posedge clock) disable iff (reset)
      res_push |-> (!res_data.matched || res_data.filter_valid))
      else $error("match reported against invalid filter");

   // Reset leaves no result pending
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> rsp_empty)
      else $error("result pending right after reset");

endmodule

// ----- tb/topic_filter_matcher_checker.sv -----
// ----------------------------------------------------------------------------
// topic_filter_matcher_checker
// Watches both channels of the topic filter matcher, predicts every result
// from the requests it accepts and compares each popped result field by field.
// ----------------------------------------------------------------------------
module topic_filter_matcher_checker #(
   parameter int MAX_FILTER_LEN = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_last,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic       rsp_matched,
   input  logic       rsp_filter_valid,
   output int         fail_count,
   output int         pending_results
);

   // Results predicted but not yet popped, oldest first
   tfm_pkg::result_type     match_q[$];

   // Predicted filter and topic state
   logic [7:0]              filter_mem [MAX_FILTER_LEN];
   int                      filter_len;
   bit                      filter_good;
   bit                      filter_loading;
   tfm_pkg::load_flags_type level_flags;
   int                      cmp_pos;
   tfm_pkg::match_mode_type cmp_mode;
   bit                      topic_has_byte;

   int                      errors = 0;
   int                      results_seen = 0;

   // Bytes actually held; the length counter runs one past the buffer
   function automatic int kept_len();
      return (filter_len > MAX_FILTER_LEN) ? MAX_FILTER_LEN : filter_len;
   endfunction

   function automatic logic [7:0] char_at(int i);
      return (i < MAX_FILTER_LEN) ? filter_mem[i] : 8'h00;
   endfunction

   function automatic void restart_topic();
      cmp_pos        = 0;
      cmp_mode       = tfm_pkg::MODE_START;
      topic_has_byte = 1'b0;
   endfunction

   // Store one filter byte and track level syntax
   function automatic void store_filter_char(logic [7:0] c);
      logic err;
      if (filter_len < MAX_FILTER_LEN) filter_mem[filter_len] = c;
      if (filter_len <= MAX_FILTER_LEN) filter_len++;
      if (c == tfm_pkg::CHAR_SLASH) begin
         // '#' must close the filter; only the error flag survives a level
         err               = level_flags.error | level_flags.hash;
         level_flags       = '0;
         level_flags.error = err;
      end else if (c == tfm_pkg::CHAR_PLUS || c == tfm_pkg::CHAR_HASH) begin
         if (level_flags.nonempty) level_flags.error = 1'b1;
         level_flags.nonempty = 1'b1;
         if (c == tfm_pkg::CHAR_PLUS) level_flags.plus = 1'b1;
         else level_flags.hash = 1'b1;
      end else begin
         if (level_flags.plus || level_flags.hash) level_flags.error = 1'b1;
         level_flags.nonempty = 1'b1;
      end
   endfunction

   // Topic level ended at filter index e: filter ends too, or only "/#" remains
   function automatic bit level_end_ok(int e);
      int n;
      n = kept_len();
      if (e >= n) return 1'b1;
      return char_at(e) == tfm_pkg::CHAR_SLASH && n == e + 2 &&
             char_at(e + 1) == tfm_pkg::CHAR_HASH;
   endfunction

   // Advance the comparison by one topic byte
   function automatic void step_topic_char(logic [7:0] c);
      int n;
      int p;
      n = kept_len();
      p = cmp_pos;
      if (cmp_mode == tfm_pkg::MODE_START) begin
         if (p < n && char_at(p) == tfm_pkg::CHAR_HASH) begin
            cmp_mode = tfm_pkg::MODE_ALL;
            return;
         end
         if (p < n && char_at(p) == tfm_pkg::CHAR_PLUS) begin
            p++;
            cmp_mode = tfm_pkg::MODE_PLUS;
         end else begin
            cmp_mode = tfm_pkg::MODE_CMP;
         end
      end
      if (cmp_mode == tfm_pkg::MODE_CMP || cmp_mode == tfm_pkg::MODE_PLUS) begin
         if (c == tfm_pkg::CHAR_SLASH) begin
            if (p < n && char_at(p) == tfm_pkg::CHAR_SLASH) begin
               p++;
               cmp_mode = tfm_pkg::MODE_START;
            end else begin
               cmp_mode = tfm_pkg::MODE_FAIL;
            end
         end else if (cmp_mode == tfm_pkg::MODE_CMP) begin
            if (p < n && char_at(p) == c) p++;
            else cmp_mode = tfm_pkg::MODE_FAIL;
         end
      end
      cmp_pos = p;
   endfunction

   // Does the topic match once it has ended here
   function automatic bit topic_ends_matched();
      int n;
      n = kept_len();
      case (cmp_mode)
         tfm_pkg::MODE_ALL: return 1'b1;
         tfm_pkg::MODE_CMP, tfm_pkg::MODE_PLUS: return level_end_ok(cmp_pos);
         tfm_pkg::MODE_START: begin
            if (cmp_pos < n && char_at(cmp_pos) == tfm_pkg::CHAR_HASH) return 1'b1;
            if (cmp_pos < n && char_at(cmp_pos) == tfm_pkg::CHAR_PLUS)
               return level_end_ok(cmp_pos + 1);
            return level_end_ok(cmp_pos);
         end
         default: return 1'b0;
      endcase
   endfunction

   // Apply one accepted request; a topic's last request queues a result
   function automatic void apply_request(logic is_topic, logic [7:0] c,
                                         logic present, logic last);
      tfm_pkg::result_type r;
      if (!is_topic) begin
         restart_topic();
         if (!filter_loading) begin
            filter_loading = 1'b1;
            filter_len     = 0;
            level_flags    = '0;
            filter_good    = 1'b0;
         end
         if (present) store_filter_char(c);
         if (last) begin
            filter_good    = !level_flags.error && filter_len > 0 &&
                             filter_len <= MAX_FILTER_LEN;
            filter_loading = 1'b0;
         end
         return;
      end
      if (present) begin
         topic_has_byte = 1'b1;
         if (filter_good) step_topic_char(c);
      end
      if (last) begin
         r.matched      = filter_good && topic_has_byte && topic_ends_matched();
         r.filter_valid = filter_good;
         match_q.push_back(r);
         restart_topic();
      end
   endfunction

   // Compare popped results, then predict from accepted requests
   always @(posedge clock) begin
      tfm_pkg::result_type want;
      if (reset) begin
         foreach (filter_mem[i]) filter_mem[i] = 8'h00;
         filter_len     = 0;
         filter_good    = 1'b0;
         filter_loading = 1'b0;
         level_flags    = '0;
         restart_topic();
         match_q.delete();
      end else begin
         if (!rsp_empty && rsp_pop) begin
            results_seen++;
            if (match_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("result %0d not expected: matched=%0b filter_valid=%0b",
                           results_seen, rsp_matched, rsp_filter_valid);
            end else begin
               want = match_q.pop_front();
               if (want.matched !== rsp_matched ||
                   want.filter_valid !== rsp_filter_valid) begin
                  errors++;
                  if (errors <= 10)
                     $display("result %0d: expected matched=%0b valid=%0b, got %0b %0b",
                              results_seen, want.matched, want.filter_valid,
                              rsp_matched, rsp_filter_valid);
               end
            end
         end
         if (req_push && !req_full)
            apply_request(req_func, req_data_byte, req_byte_present, req_last);
      end
      fail_count      <= errors;
      pending_results <= match_q.size();
   end

endmodule

// ----- tb/topic_filter_matcher_top_test.sv -----
// ----------------------------------------------------------------------------
// topic_filter_matcher_top_test
// Drives filters and topics into the matcher: a short directed run over the
// wildcard and syntax corner cases, buffer-size filters, then random filters
// with topics derived from them, under random stalls on both channels.
// ----------------------------------------------------------------------------
module topic_filter_matcher_top_test;

   localparam int         ITEM_TARGET = 1750;
   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam int         LONG_HOLD   = 300;
   localparam logic       IS_FILTER   = 1'b0;
   localparam logic       IS_TOPIC    = 1'b1;
   localparam logic [7:0] CHAR_A      = "a";
   localparam logic [7:0] CHAR_B      = "b";

   typedef logic [7:0] byte_queue_type [$];

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_push = 1'b0;
   logic           req_func = 1'b0;
   logic [7:0]     req_data_byte = 8'h00;
   logic           req_byte_present = 1'b0;
   logic           req_last = 1'b0;
   logic           rsp_pop = 1'b0;
   logic           req_full;
   logic           rsp_empty;
   logic           rsp_matched;
   logic           rsp_filter_valid;

   int             fail_count;
   int             pending_results;
   int             items_sent = 0;
   int             cycle_count = 0;
   int             idle_odds = 8;
   int             hold_asks = 0;
   bit             quiet = 1'b0;
   byte_queue_type cur_filter;

   topic_filter_matcher_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_matched      (rsp_matched),
      .rsp_filter_valid (rsp_filter_valid)
   );

   topic_filter_matcher_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_matched      (rsp_matched),
      .rsp_filter_valid (rsp_filter_valid),
      .fail_count       (fail_count),
      .pending_results  (pending_results)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("topic_filter_matcher_top: mismatch");
      $finish;
   end

   // Result side: random stall bursts, plus long hold-offs on request
   initial begin
      int stall_left;
      int hold_left;
      int holds_done;
      stall_left = 0;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (holds_done < hold_asks) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            rsp_pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // One request, with an occasional idle burst ahead of it
   task automatic send_item(input logic is_topic, input logic [7:0] c,
                            input logic present, input logic last);
      if (items_sent % 64 == 0) begin
         case ($urandom_range(0, 2))
            0: idle_odds <= 0;
            1: idle_odds <= 3;
            default: idle_odds <= 10;
         endcase
      end
      if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_func         <= is_topic;
      req_data_byte    <= c;
      req_byte_present <= present;
      req_last         <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
   endtask

   // A string of bytes; sparse adds byte-less requests and a byte-less close
   task automatic send_string(input logic is_topic, input byte_queue_type s,
                              input bit close, input bit sparse);
      bit tail;
      tail = close && (s.size() == 0 || (sparse && $urandom_range(0, 6) == 0));
      foreach (s[i]) begin
         if (sparse && $urandom_range(0, 11) == 0)
            send_item(is_topic, 8'($urandom), 1'b0, 1'b0);
         send_item(is_topic, s[i], 1'b1, close && !tail && i == s.size() - 1);
      end
      if (tail) send_item(is_topic, 8'($urandom), 1'b0, 1'b1);
   endtask

   // Stop offering requests until every predicted result is out
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Level character; filters never get a wildcard or separator this way
   function automatic logic [7:0] pick_char(bit for_filter);
      logic [7:0] c;
      if ($urandom_range(0, 2) != 0) return CHAR_A + 8'($urandom_range(0, 2));
      do c = 8'($urandom);
      while (c == tfm_pkg::CHAR_SLASH ||
             (for_filter && (c == tfm_pkg::CHAR_PLUS || c == tfm_pkg::CHAR_HASH)));
      return c;
   endfunction

   function automatic void add_word(inout byte_queue_type s, input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) s.push_back(pick_char(1'b0));
   endfunction

   // Mostly well-formed filter; some syntax errors and empty filters
   function automatic void make_filter(output byte_queue_type f);
      int levels;
      int kind;
      f = {};
      levels = $urandom_range(1, 4);
      for (int i = 0; i < levels; i++) begin
         if (i > 0) f.push_back(tfm_pkg::CHAR_SLASH);
         kind = $urandom_range(0, 99);
         if (i == levels - 1 && kind < 25) f.push_back(tfm_pkg::CHAR_HASH);
         else if (kind < 45) f.push_back(tfm_pkg::CHAR_PLUS);
         else if (kind >= 52) repeat ($urandom_range(1, 3)) f.push_back(pick_char(1'b1));
         // otherwise the level stays empty
      end
      if ($urandom_range(0, 7) == 0)
         f.insert($urandom_range(0, f.size()),
                  $urandom_range(0, 1) ? tfm_pkg::CHAR_PLUS : tfm_pkg::CHAR_HASH);
      if ($urandom_range(0, 29) == 0) f = {};
   endfunction

   // Topic built to fit the filter, then sometimes damaged
   function automatic void make_topic(input byte_queue_type f, output byte_queue_type t);
      int start;
      int stop;
      int n;
      t = {};
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(0, 6))
            t.push_back($urandom_range(0, 4) == 0 ? tfm_pkg::CHAR_SLASH : pick_char(1'b0));
         return;
      end
      start = 0;
      do begin
         stop = start;
         while (stop < f.size() && f[stop] != tfm_pkg::CHAR_SLASH) stop++;
         if (stop == start + 1 && f[start] == tfm_pkg::CHAR_PLUS) begin
            add_word(t, 0, 3);
         end else if (stop == start + 1 && f[start] == tfm_pkg::CHAR_HASH) begin
            // '#' takes any number of levels, none included
            n = $urandom_range(0, 2);
            if (n == 0 && t.size() > 0) begin
               t.pop_back();
            end else begin
               for (int k = 0; k < (n == 0 ? 1 : n); k++) begin
                  if (k > 0) t.push_back(tfm_pkg::CHAR_SLASH);
                  add_word(t, 1, 3);
               end
            end
         end else begin
            for (int k = start; k < stop; k++) t.push_back(f[k]);
         end
         if (stop < f.size()) t.push_back(tfm_pkg::CHAR_SLASH);
         start = stop + 1;
      end while (stop < f.size());
      if (t.size() > 0 && $urandom_range(0, 4) == 0)
         t[$urandom_range(0, t.size() - 1)] =
            $urandom_range(0, 3) == 0 ? tfm_pkg::CHAR_SLASH : pick_char(1'b0);
      else if ($urandom_range(0, 9) == 0) begin
         t.push_back(tfm_pkg::CHAR_SLASH);
         add_word(t, 1, 2);
      end
   endfunction

   // Request side and verdict
   initial begin
      byte_queue_type f;
      byte_queue_type t;
      byte_queue_type half;
      int             r;
      int             cut;
      bit             second_hold;
      second_hold = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: no filter yet, wildcards, extreme bytes, syntax errors
      send_string(IS_TOPIC, {CHAR_A}, 1'b1, 1'b0);
      send_string(IS_FILTER, {tfm_pkg::CHAR_HASH}, 1'b1, 1'b0);
      send_string(IS_TOPIC, {CHAR_A, tfm_pkg::CHAR_SLASH, CHAR_B}, 1'b1, 1'b0);
      send_item(IS_TOPIC, 8'hFF, 1'b0, 1'b1);          // topic with no bytes
      send_string(IS_FILTER, {tfm_pkg::CHAR_PLUS, tfm_pkg::CHAR_SLASH, 8'hFF}, 1'b1, 1'b0);
      send_string(IS_TOPIC, {8'h00, tfm_pkg::CHAR_SLASH, 8'hFF}, 1'b1, 1'b0);
      send_string(IS_TOPIC, {8'h00, tfm_pkg::CHAR_SLASH, 8'hFE}, 1'b1, 1'b0);
      send_string(IS_FILTER, {CHAR_A, tfm_pkg::CHAR_PLUS}, 1'b1, 1'b0);  // '+' inside a level
      send_string(IS_TOPIC, {CHAR_A, tfm_pkg::CHAR_PLUS}, 1'b1, 1'b0);
      send_item(IS_FILTER, 8'h00, 1'b0, 1'b1);         // empty filter
      send_string(IS_TOPIC, {CHAR_A}, 1'b1, 1'b0);
      // topic arriving while a filter is half loaded
      send_string(IS_FILTER, {CHAR_A}, 1'b0, 1'b0);
      send_string(IS_TOPIC, {CHAR_A}, 1'b1, 1'b0);
      send_string(IS_FILTER, {tfm_pkg::CHAR_SLASH, tfm_pkg::CHAR_HASH}, 1'b1, 1'b0);
      // topic cut off by a new filter, then "a" against "a/#"
      send_string(IS_TOPIC, {CHAR_B}, 1'b0, 1'b0);
      send_string(IS_FILTER, {CHAR_A, tfm_pkg::CHAR_SLASH, tfm_pkg::CHAR_HASH}, 1'b1, 1'b0);
      send_string(IS_TOPIC, {CHAR_A}, 1'b1, 1'b0);
      drain();

      // Filter that fills the buffer exactly
      f = {};
      for (int i = 0; i < 254; i++)
         f.push_back(i % 4 == 3 ? tfm_pkg::CHAR_SLASH : CHAR_A + 8'(i % 4));
      f.push_back(tfm_pkg::CHAR_SLASH);
      f.push_back(tfm_pkg::CHAR_HASH);
      send_string(IS_FILTER, f, 1'b1, 1'b1);
      t = f[0:253];
      send_string(IS_TOPIC, t, 1'b1, 1'b0);
      t.push_back(tfm_pkg::CHAR_SLASH);
      t.push_back(CHAR_B);
      send_string(IS_TOPIC, t, 1'b1, 1'b0);
      t[200] = CHAR_B;
      send_string(IS_TOPIC, t, 1'b1, 1'b0);
      drain();

      // Long result hold-off while short topics keep coming
      hold_asks <= hold_asks + 1;
      repeat (40) send_string(IS_TOPIC, {CHAR_A}, 1'b1, 1'b0);
      drain();

      // Filter longer than the buffer
      f = {};
      repeat (300) f.push_back(CHAR_A);
      send_string(IS_FILTER, f, 1'b1, 1'b0);
      send_string(IS_TOPIC, {CHAR_A}, 1'b1, 1'b0);
      drain();

      make_filter(cur_filter);
      send_string(IS_FILTER, cur_filter, 1'b1, 1'b1);

      // Random filters and topics
      while (items_sent < ITEM_TARGET) begin
         if (items_sent > ITEM_TARGET - 200) quiet <= 1'b1;
         if (!second_hold && items_sent > 1100) begin
            second_hold = 1'b1;
            hold_asks <= hold_asks + 1;
         end
         r = $urandom_range(0, 99);
         if (r < 14) begin
            make_filter(f);
            send_string(IS_FILTER, f, 1'b1, 1'b1);
            cur_filter = f;
         end else if (r < 18) begin
            // topic in the middle of a filter load
            make_filter(f);
            cut = $urandom_range(0, f.size());
            half = {};
            for (int i = 0; i < cut; i++) half.push_back(f[i]);
            send_string(IS_FILTER, half, 1'b0, 1'b1);
            make_topic(cur_filter, t);
            send_string(IS_TOPIC, t, 1'b1, 1'b1);
            half = {};
            for (int i = cut; i < f.size(); i++) half.push_back(f[i]);
            send_string(IS_FILTER, half, 1'b1, 1'b1);
            cur_filter = f;
         end else if (r < 22) begin
            // unfinished topic dropped by a new filter
            make_topic(cur_filter, t);
            if (t.size() > 0) t.pop_back();
            send_string(IS_TOPIC, t, 1'b0, 1'b1);
            make_filter(f);
            send_string(IS_FILTER, f, 1'b1, 1'b1);
            cur_filter = f;
         end else if (r < 26) begin
            repeat ($urandom_range(1, 6))
               send_item(1'($urandom_range(0, 1)), 8'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (r == 26) begin
            drain();
         end else begin
            make_topic(cur_filter, t);
            send_string(IS_TOPIC, t, 1'b1, 1'b1);
         end
      end

      drain();
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("topic_filter_matcher_top: match");
      else
         $display("topic_filter_matcher_top: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/tfm_pkg.sv
sv/tfm_front.sv
sv/tfm_back.sv
sv/tfm_result_queue.sv
sv/topic_filter_matcher_top.sv
tb/topic_filter_matcher_checker.sv
tb/topic_filter_matcher_top_test.sv
